// ===== sv/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg: shared types and constants for the unicycle pose integrator
// Fixed-point constants, mode and register codes, controller states and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package upi_pkg;

	// 0.05 s period in Q0.24
	localparam logic signed [31:0] DT_Q        = 32'sd838861;
	// angle constants in Q.24
	localparam logic [47:0]        TWO_PI_Q24  = 48'd105414357;
	localparam logic signed [28:0] TWO_PI_S    = 29'sd105414357;
	localparam logic signed [28:0] PI_S        = 29'sd52707179;
	localparam logic signed [28:0] HALF_PI_S   = 29'sd26353589;
	// CORDIC start value (inverse gain) in Q2.30
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	// top shift of the modulo reduction: 2^47 / 2pi stays below 2^21
	localparam logic [4:0]         RED_TOP     = 5'd20;

	// motion modes
	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_STRAIGHT = 2'd1,
		MODE_TURN     = 2'd2,
		MODE_CURVE    = 2'd3
	} mode_t;

	// register indexes
	localparam logic [2:0] CFG_MODE     = 3'd0;
	localparam logic [2:0] CFG_LIN      = 3'd1;
	localparam logic [2:0] CFG_ANG      = 3'd2;
	localparam logic [2:0] CFG_TDIST    = 3'd3;
	localparam logic [2:0] CFG_TANG     = 3'd4;

	// controller states
	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_MUL    = 14'b00000000000010,
		S_XLIN   = 14'b00000000000100,
		S_HTURN  = 14'b00000000001000,
		S_CSTEP  = 14'b00000000010000,
		S_RED    = 14'b00000000100000,
		S_ROT    = 14'b00000001000000,
		S_CMX    = 14'b00000010000000,
		S_CX     = 14'b00000100000000,
		S_CY     = 14'b00001000000000,
		S_CH     = 14'b00010000000000,
		S_QSTART = 14'b00100000000000,
		S_QFIN   = 14'b01000000000000,
		S_SPARE  = 14'b10000000000000
	} state_t;

	// arctangent of 2^-i in Q.30
	function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
		logic signed [34:0] v;
		case (idx)
			5'd0:  v = 35'sd843314857;
			5'd1:  v = 35'sd497837829;
			5'd2:  v = 35'sd263043837;
			5'd3:  v = 35'sd133525159;
			5'd4:  v = 35'sd67021687;
			5'd5:  v = 35'sd33543516;
			5'd6:  v = 35'sd16775851;
			5'd7:  v = 35'sd8388437;
			5'd8:  v = 35'sd4194283;
			5'd9:  v = 35'sd2097149;
			5'd10: v = 35'sd1048576;
			5'd11: v = 35'sd524288;
			5'd12: v = 35'sd262144;
			5'd13: v = 35'sd131072;
			5'd14: v = 35'sd65536;
			5'd15: v = 35'sd32768;
			5'd16: v = 35'sd16384;
			5'd17: v = 35'sd8192;
			5'd18: v = 35'sd4096;
			5'd19: v = 35'sd2048;
			5'd20: v = 35'sd1024;
			5'd21: v = 35'sd512;
			5'd22: v = 35'sd256;
			5'd23: v = 35'sd128;
			5'd24: v = 35'sd64;
			5'd25: v = 35'sd32;
			5'd26: v = 35'sd16;
			5'd27: v = 35'sd8;
			5'd28: v = 35'sd4;
			5'd29: v = 35'sd2;
			default: v = 35'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/unicycle_pose_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_unit: dead-reckoning pose integrator
// Advances x, y and heading once per tick, then reports commands, pose,
// yaw quaternion and yaw rate. Sine and cosine come from one iterative CORDIC.
// ----------------------------------------------------------------------------
// Per tick: idle, or a straight/turn tick that does not move, runs one sincos pass;
// a moving straight/turn tick first updates x or heading; curve runs two passes.
// The modulo-2pi reduction (21 shift-subtract steps) and the CORDIC rotations
// (one per cycle) dominate; both sincos passes share them, and all products use one multiplier.
// A new tick is accepted only in idle; a tick with bit 0 clear has no effect.
// Reset (arst_n low) clears pose, registers and handshake state at once.
module unicycle_pose_integrator_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream: [0] tick
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,
	// output stream: [23:0] cmd_linear, [47:24] cmd_angular, [79:48] pos_x,
	// [111:80] pos_y, [159:112] heading_out, [177:160] quat_z,
	// [195:178] quat_w, [219:196] yaw_rate, [220] saturated
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,
	// register write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import upi_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	// registers and state
	state_t              st_q, ret_q;
	mode_t               mode_q;
	logic signed [23:0]  lin_q, ang_q;
	logic signed [31:0]  tdist_q, tang_q;
	logic signed [31:0]  x_q, y_q;
	logic signed [47:0]  hd_q;
	logic signed [23:0]  cmd_lin_q, cmd_ang_q;
	logic                sat_q;
	logic signed [31:0]  mul_a_q, mul_b_q, step_q;
	logic signed [63:0]  prod_q;
	logic [47:0]         red_mag_q;
	logic                red_neg_q;
	logic [4:0]          red_k_q;
	logic signed [33:0]  cx_q, cy_q, cos_q, sin_q;
	logic signed [34:0]  cz_q;
	logic [IW-1:0]       it_q;
	logic                fold_q, sc_quat_q;
	logic                m_tvalid_q;
	logic [223:0]        m_tdata_q;

	// rounding shift, ties toward +infinity
	function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int s);
		return (p + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// saturate to 32 bits, flag in the top bit
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF)
			return {1'b1, 32'h7FFFFFFF};
		if (v < -64'sh80000000)
			return {1'b1, 32'h80000000};
		return {1'b0, v[31:0]};
	endfunction

	// saturate to 48 bits, flag in the top bit
	function automatic logic [48:0] sat48(input logic signed [63:0] v);
		if (v > 64'sh7FFFFFFFFFFF)
			return {1'b1, 48'h7FFFFFFFFFFF};
		if (v < -64'sh800000000000)
			return {1'b1, 48'h800000000000};
		return {1'b0, v[47:0]};
	endfunction

	// Q2.30 to Q1.16 with clamp to +-1
	function automatic logic [17:0] q16(input logic signed [33:0] v);
		logic signed [63:0] r;
		r = rnd(64'(v), 14);
		if (r > 64'sd65536)
			return 18'sd65536;
		if (r < -64'sd65536)
			return -18'sd65536;
		return r[17:0];
	endfunction

	// shared multiplier
	logic signed [63:0] mul_p;
	assign mul_p = mul_a_q * mul_b_q;

	// turn decision
	logic [48:0]        ha;
	logic [32:0]        ta;
	logic               turn_go;
	logic signed [23:0] turn_cmd;
	always_comb begin
		ha = hd_q[47] ? 49'(-(49'(hd_q))) : 49'(hd_q);
		ta = tang_q[31] ? 33'(-(33'(tang_q))) : 33'(tang_q);
		turn_go = ha < 49'(ta);
		if (tang_q > 32'sd0)
			turn_cmd = ang_q;
		else if (ang_q == -24'sd8388608)
			turn_cmd = 24'sd8388607;
		else
			turn_cmd = -ang_q;
	end

	// one shift-subtract step of the modulo 2pi, then the fold to +-pi/2
	logic [47:0]        red_sub, red_next;
	logic signed [28:0] r0, r1, r2;
	logic               fold_neg;
	logic signed [34:0] fold_z;
	always_comb begin
		red_sub  = TWO_PI_Q24 << red_k_q;
		red_next = (red_mag_q >= red_sub) ? red_mag_q - red_sub : red_mag_q;
		r0 = red_neg_q ? -$signed({2'b00, red_next[26:0]}) : $signed({2'b00, red_next[26:0]});
		r1 = r0;
		if (r0 > PI_S)
			r1 = r0 - TWO_PI_S;
		else if (r0 < -PI_S)
			r1 = r0 + TWO_PI_S;
		r2 = r1;
		fold_neg = 1'b0;
		if (r1 > HALF_PI_S) begin
			r2 = r1 - PI_S;
			fold_neg = 1'b1;
		end else if (r1 < -HALF_PI_S) begin
			r2 = r1 + PI_S;
			fold_neg = 1'b1;
		end
		fold_z = 35'(r2) <<< 6;
	end

	// CORDIC rotation step
	logic signed [33:0] xs, ys, nx, ny;
	logic signed [34:0] nz, at;
	always_comb begin
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		at = atan_q30(5'(it_q));
		if (cz_q >= 35'sd0) begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - at;
		end else begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + at;
		end
	end

	// position and heading updates
	logic [32:0] x_lin_u, x_cur_u, y_cur_u;
	logic [48:0] h_turn_u, h_cur_u;
	always_comb begin
		x_lin_u  = sat32(64'(x_q) + rnd(prod_q, 24));
		x_cur_u  = sat32(64'(x_q) + rnd(prod_q, 30));
		y_cur_u  = sat32(64'(y_q) + rnd(prod_q, 30));
		h_turn_u = sat48(64'(hd_q) + rnd(prod_q, 16));
		h_cur_u  = h_turn_u;
	end

	logic signed [47:0] half_hd;
	assign half_hd = hd_q >>> 1;

	// commands for the tick being accepted
	logic signed [23:0] cmd_lin_d, cmd_ang_d;
	always_comb begin
		cmd_lin_d = '0;
		cmd_ang_d = '0;
		case (mode_q)
			MODE_STRAIGHT: if (x_q < tdist_q) cmd_lin_d = lin_q;
			MODE_TURN:     if (turn_go) cmd_ang_d = turn_cmd;
			MODE_CURVE: begin
				cmd_lin_d = lin_q;
				cmd_ang_d = ang_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			mode_q <= MODE_IDLE;
			lin_q <= '0;
			ang_q <= '0;
			tdist_q <= '0;
			tang_q <= '0;
			x_q <= '0;
			y_q <= '0;
			hd_q <= '0;
			cmd_lin_q <= '0;
			cmd_ang_q <= '0;
			sat_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			step_q <= '0;
			prod_q <= '0;
			red_mag_q <= '0;
			red_neg_q <= 1'b0;
			red_k_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			cos_q <= '0;
			sin_q <= '0;
			it_q <= '0;
			fold_q <= 1'b0;
			sc_quat_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			// register writes
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MODE:  mode_q <= mode_t'(cfg_data[1:0]);
					CFG_LIN:   lin_q <= cfg_data[23:0];
					CFG_ANG:   ang_q <= cfg_data[23:0];
					CFG_TDIST: tdist_q <= cfg_data;
					CFG_TANG:  tang_q <= cfg_data;
					default:   ;
				endcase
			end
			// result transfer; a reload in S_QFIN takes precedence
			if (m_tvalid_q && m_tready && st_q != S_QFIN)
				m_tvalid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (s_tvalid && s_tdata[0]) begin
						sat_q <= 1'b0;
						cmd_lin_q <= cmd_lin_d;
						cmd_ang_q <= cmd_ang_d;
						mul_b_q <= DT_Q;
						case (mode_q)
							MODE_STRAIGHT: begin
								if (x_q < tdist_q) begin
									mul_a_q <= 32'(lin_q);
									ret_q <= S_XLIN;
									st_q <= S_MUL;
								end else
									st_q <= S_QSTART;
							end
							MODE_TURN: begin
								if (turn_go) begin
									mul_a_q <= 32'(turn_cmd);
									ret_q <= S_HTURN;
									st_q <= S_MUL;
								end else
									st_q <= S_QSTART;
							end
							MODE_CURVE: begin
								mul_a_q <= 32'(lin_q);
								ret_q <= S_CSTEP;
								st_q <= S_MUL;
							end
							default: st_q <= S_QSTART;
						endcase
					end
				end
				S_MUL: begin
					prod_q <= mul_p;
					st_q <= ret_q;
				end
				S_XLIN: begin
					x_q <= x_lin_u[31:0];
					sat_q <= sat_q | x_lin_u[32];
					st_q <= S_QSTART;
				end
				S_HTURN: begin
					hd_q <= h_turn_u[47:0];
					sat_q <= sat_q | h_turn_u[48];
					st_q <= S_QSTART;
				end
				S_CSTEP: begin
					// distance step, then sincos of the old heading
					step_q <= 32'(rnd(prod_q, 24));
					red_mag_q <= hd_q[47] ? 48'(-hd_q) : 48'(hd_q);
					red_neg_q <= hd_q[47];
					red_k_q <= RED_TOP;
					sc_quat_q <= 1'b0;
					st_q <= S_RED;
				end
				S_RED: begin
					red_mag_q <= red_next;
					red_k_q <= red_k_q - 5'd1;
					if (red_k_q == 5'd0) begin
						cx_q <= GAIN_Q30;
						cy_q <= '0;
						cz_q <= fold_z;
						fold_q <= fold_neg;
						it_q <= '0;
						st_q <= S_ROT;
					end
				end
				S_ROT: begin
					cx_q <= nx;
					cy_q <= ny;
					cz_q <= nz;
					it_q <= it_q + 1'b1;
					if (it_q == IW'(CORDIC_STEPS - 1)) begin
						cos_q <= fold_q ? -nx : nx;
						sin_q <= fold_q ? -ny : ny;
						st_q <= sc_quat_q ? S_QFIN : S_CMX;
					end
				end
				S_CMX: begin
					mul_a_q <= step_q;
					mul_b_q <= 32'(cos_q);
					ret_q <= S_CX;
					st_q <= S_MUL;
				end
				S_CX: begin
					x_q <= x_cur_u[31:0];
					sat_q <= sat_q | x_cur_u[32];
					mul_a_q <= step_q;
					mul_b_q <= 32'(sin_q);
					ret_q <= S_CY;
					st_q <= S_MUL;
				end
				S_CY: begin
					y_q <= y_cur_u[31:0];
					sat_q <= sat_q | y_cur_u[32];
					mul_a_q <= 32'(ang_q);
					mul_b_q <= DT_Q;
					ret_q <= S_CH;
					st_q <= S_MUL;
				end
				S_CH: begin
					hd_q <= h_cur_u[47:0];
					sat_q <= sat_q | h_cur_u[48];
					st_q <= S_QSTART;
				end
				S_QSTART: begin
					// sincos of the half heading for the quaternion
					red_mag_q <= half_hd[47] ? 48'(-half_hd) : 48'(half_hd);
					red_neg_q <= half_hd[47];
					red_k_q <= RED_TOP;
					sc_quat_q <= 1'b1;
					st_q <= S_RED;
				end
				S_QFIN: begin
					// load the output register once it is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q <= {3'b000, sat_q, ang_q, q16(cos_q), q16(sin_q),
							hd_q, y_q, x_q, cmd_ang_q, cmd_lin_q};
						m_tvalid_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// checks
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state register not one-hot");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_ROT |-> it_q <= IW'(CORDIC_STEPS - 1)) else $error("CORDIC index out of range");
	a_idle_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && mode_q == MODE_IDLE) |-> (m_tdata_q[47:0] == 48'd0 && !m_tdata_q[220]))
		else $error("idle mode gave a command or saturation");
	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> ($signed(m_tdata_q[177:160]) <= 18'sd65536 &&
		$signed(m_tdata_q[177:160]) >= -18'sd65536)) else $error("quat_z out of range");
	a_red_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RED && red_k_q == 5'd0) |=> st_q == S_ROT) else $error("reduction did not end");

endmodule
